>>> src/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared widths, codes and types of the state-space model step block.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 3;
    localparam int SEL_W      = 2;
    localparam int POS_W      = 3;
    localparam int STATUS_W   = 4;
    localparam int TYPE_W     = 2;
    localparam int COUNT_W    = 4;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int RGN_W      = 2;
    localparam int PROD_W     = 64;
    // 48-bit rounded terms, at most 30 of them per row, plus margin
    localparam int ACC_W      = 54;
    localparam int RESULT_LIMIT = 8;

    localparam int DEF_MAX_STATES  = 8;
    localparam int DEF_MAX_INPUTS  = 8;
    localparam int DEF_MAX_OUTPUTS = 8;

    localparam logic [KIND_W-1:0] KIND_LOAD_COEF  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_STATE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_INPUT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UPDATE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OUTPUT     = 3'd4;

    localparam logic [SEL_W-1:0] MAT_A = 2'd0;
    localparam logic [SEL_W-1:0] MAT_B = 2'd1;
    localparam logic [SEL_W-1:0] MAT_C = 2'd2;
    localparam logic [SEL_W-1:0] MAT_D = 2'd3;

    // regions of the vector memory
    localparam logic [RGN_W-1:0] RGN_X0 = 2'd0;
    localparam logic [RGN_W-1:0] RGN_X1 = 2'd1;
    localparam logic [RGN_W-1:0] RGN_U  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK             = 4'd0;
    localparam logic [STATUS_W-1:0] STS_INPUT_IGNORED  = 4'd1;
    localparam logic [STATUS_W-1:0] STS_NO_A           = 4'd2;
    localparam logic [STATUS_W-1:0] STS_NO_STATE       = 4'd3;
    localparam logic [STATUS_W-1:0] STS_INPUT_REQUIRED = 4'd4;
    localparam logic [STATUS_W-1:0] STS_NO_B           = 4'd5;
    localparam logic [STATUS_W-1:0] STS_NO_C           = 4'd6;
    localparam logic [STATUS_W-1:0] STS_NO_D           = 4'd7;
    localparam logic [STATUS_W-1:0] STS_TYPE_UNSET     = 4'd8;

    localparam logic [TYPE_W-1:0] SYS_UNSET       = 2'd0;
    localparam logic [TYPE_W-1:0] SYS_AUTONOMOUS  = 2'd1;
    localparam logic [TYPE_W-1:0] SYS_DYNAMIC     = 2'd2;
    localparam logic [TYPE_W-1:0] SYS_FEEDTHROUGH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    // 1.0 in Q16.16
    localparam logic signed [VALUE_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic copy;
    } term_ctl_t;

    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] value;
    } mac_res_t;

endpackage

>>> src/ssm_mac.sv
// ----------------------------------------------------------------------------
// ssm_mac
// Multiply-accumulate unit: Q16.16 products rounded half up, exact row sum,
// saturated to 32 bits at the end of each row.
// ----------------------------------------------------------------------------
module ssm_mac
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  ssm_pkg::term_ctl_t                 term,
    input  logic signed [ssm_pkg::VALUE_W-1:0] coef,
    input  logic signed [ssm_pkg::VALUE_W-1:0] vec,
    output ssm_pkg::mac_res_t                  res
);
    import ssm_pkg::*;

    logic signed [VALUE_W-1:0] coef_op;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    term_ctl_t                 stage_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   term_shift;
    logic signed [ACC_W-1:0]   term_round;
    logic                      sat_hi;
    logic                      sat_lo;
    logic signed [VALUE_W-1:0] sum_next;
    logic signed [VALUE_W-1:0] sum_reg;
    logic                      done_reg;

    // a copy term multiplies by one, which passes the value through exactly
    assign coef_op   = term.copy ? Q_ONE : coef;
    assign prod_next = coef_op * vec;

    // floor((p + 2^15) / 2^16) = (p >>> 16) + p[15]
    assign term_shift = {{(ACC_W-48){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:16]};
    assign term_round = {{(ACC_W-1){1'b0}}, prod_reg[15]};
    assign acc_base   = stage_reg.first ? '0 : acc_reg;
    assign acc_next   = acc_base + term_shift + term_round;

    always_comb
    begin
        sat_hi = !acc_next[ACC_W-1] && (acc_next[ACC_W-2:VALUE_W-1] != '0);
        sat_lo = acc_next[ACC_W-1] && !(&acc_next[ACC_W-2:VALUE_W-1]);
        if (sat_hi)
        begin
            sum_next = 32'sh7FFF_FFFF;
        end
        else if (sat_lo)
        begin
            sum_next = 32'sh8000_0000;
        end
        else
        begin
            sum_next = acc_next[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= term;
            done_reg  <= stage_reg.valid && stage_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (stage_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (stage_reg.valid && stage_reg.last)
        begin
            sum_reg <= sum_next;
        end
    end

    assign res.done  = done_reg;
    assign res.value = sum_reg;

endmodule

>>> src/state_space_model_step_top.sv
// ----------------------------------------------------------------------------
// state_space_model_step_top
// Discrete-time linear state-space model x' = A x (+ B u), y = C x (+ D u),
// Q16.16, coefficients and vectors held in synchronous memories.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the coefficient memory of
// 4*D*D words, D being the largest of the three size parameters rounded up to
// a power of two, clearing the vector memory with it; it takes no item until
// then. Load items and rejected items are answered from the idle state. All
// products go through one shared multiply-accumulate unit, one term a cycle,
// fed by the coefficient and vector memories: a row issues its n state terms
// (plus m input terms) and then waits for its result. An update runs n such
// rows plus a copy row for each further row up to MAX_STATES; an output item
// runs p rows, each result entering the output register only once the one
// before it has been taken.
// ----------------------------------------------------------------------------
module state_space_model_step_top
#(
    parameter int MAX_STATES  = ssm_pkg::DEF_MAX_STATES,
    parameter int MAX_INPUTS  = ssm_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = ssm_pkg::DEF_MAX_OUTPUTS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssm_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ssm_pkg::KIND_W-1:0]          kind,
    input  logic [ssm_pkg::SEL_W-1:0]           matrix_sel,
    input  logic [ssm_pkg::POS_W-1:0]           row,
    input  logic [ssm_pkg::POS_W-1:0]           column,
    input  logic signed [ssm_pkg::VALUE_W-1:0]  value,
    input  logic                                use_input,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ssm_pkg::STATUS_W-1:0]        status,
    output logic [ssm_pkg::POS_W-1:0]           index,
    output logic signed [ssm_pkg::VALUE_W-1:0]  out_value,
    output logic                                last
);
    import ssm_pkg::*;

    localparam int DIM_SI    = (MAX_STATES > MAX_INPUTS) ? MAX_STATES : MAX_INPUTS;
    localparam int DIM       = (DIM_SI > MAX_OUTPUTS) ? DIM_SI : MAX_OUTPUTS;
    localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CW        = IDX_W + 1;
    localparam int CADDR_W   = SEL_W + 2 * IDX_W;
    localparam int VADDR_W   = RGN_W + IDX_W;
    localparam int CDEPTH    = 2 ** CADDR_W;
    localparam int VDEPTH    = 2 ** VADDR_W;
    localparam int OUT_LIMIT = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_WAIT  = 4'b1000
    } seq_state_t;

    function automatic logic [CW-1:0] clamp_count(input logic [COUNT_W-1:0] c,
                                                  input int max_v);
        logic [CW-1:0] r;
        if (c == '0)
        begin
            r = CW'(1);
        end
        else if (32'(c) > max_v)
        begin
            r = CW'(max_v);
        end
        else
        begin
            r = CW'(c);
        end
        return r;
    endfunction

    seq_state_t state_reg, state_next;
    logic [CADDR_W-1:0] clr_reg, clr_next;

    logic [TYPE_W-1:0]  system_type_reg, system_type_next;
    logic [COUNT_W-1:0] state_count_reg, state_count_next;
    logic [COUNT_W-1:0] input_count_reg, input_count_next;
    logic [COUNT_W-1:0] output_count_reg, output_count_next;

    logic [3:0] present_reg, present_next;
    logic       state_valid_reg, state_valid_next;
    logic       bank_reg, bank_next;

    logic                op_out_reg, op_out_next;
    logic                add_in_reg, add_in_next;
    logic                phase_reg, phase_next;
    logic [STATUS_W-1:0] run_status_reg, run_status_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       m_reg, m_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic [CW-1:0]       row_reg, row_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                res_pending_reg, res_pending_next;

    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [POS_W-1:0]          index_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      last_reg;

    logic                      load_out;
    logic [STATUS_W-1:0]       ld_status;
    logic [POS_W-1:0]          ld_index;
    logic signed [VALUE_W-1:0] ld_value;
    logic                      ld_last;

    logic signed [VALUE_W-1:0] coef_mem [CDEPTH];
    logic signed [VALUE_W-1:0] vec_mem  [VDEPTH];
    logic                      cm_we;
    logic [CADDR_W-1:0]        cm_waddr;
    logic [CADDR_W-1:0]        cm_raddr;
    logic signed [VALUE_W-1:0] cm_wdata;
    logic signed [VALUE_W-1:0] coef_rd_reg;
    logic                      vm_we;
    logic [VADDR_W-1:0]        vm_waddr;
    logic [VADDR_W-1:0]        vm_raddr;
    logic signed [VALUE_W-1:0] vm_wdata;
    logic signed [VALUE_W-1:0] vec_rd_reg;

    term_ctl_t term_reg, term_next;
    mac_res_t  mac_res;

    logic             in_accept;
    logic             coef_in_range;
    logic             row_lt_s, row_lt_i, row_lt_o, col_lt_s, col_lt_i;
    logic [RGN_W-1:0] cur_rgn, oth_rgn;
    logic             copy_row;
    logic [CW-1:0]    j_inc, row_inc;
    logic             term_last;
    logic             res_ready;
    logic [IDX_W-1:0] row_idx, j_idx;
    logic [SEL_W-1:0] rd_mat;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;

    assign row_lt_s = 32'(row) < MAX_STATES;
    assign row_lt_i = 32'(row) < MAX_INPUTS;
    assign row_lt_o = 32'(row) < MAX_OUTPUTS;
    assign col_lt_s = 32'(column) < MAX_STATES;
    assign col_lt_i = 32'(column) < MAX_INPUTS;

    always_comb
    begin
        case (matrix_sel)
            MAT_A:   coef_in_range = row_lt_s && col_lt_s;
            MAT_B:   coef_in_range = row_lt_s && col_lt_i;
            MAT_C:   coef_in_range = row_lt_o && col_lt_s;
            default: coef_in_range = row_lt_o && col_lt_i;
        endcase
    end

    // old state lives in the current bank, an update writes the other one
    assign cur_rgn = bank_reg ? RGN_X1 : RGN_X0;
    assign oth_rgn = bank_reg ? RGN_X0 : RGN_X1;

    assign row_idx   = IDX_W'(row_reg);
    assign j_idx     = IDX_W'(j_reg);
    assign copy_row  = !op_out_reg && (row_reg >= n_reg);
    assign j_inc     = j_reg + CW'(1);
    assign row_inc   = row_reg + CW'(1);
    assign term_last = copy_row
                     || (phase_reg ? (j_inc == m_reg) : ((j_inc == n_reg) && !add_in_reg));
    assign res_ready = res_pending_reg || mac_res.done;

    always_comb
    begin
        if (op_out_reg)
        begin
            rd_mat = phase_reg ? MAT_D : MAT_C;
        end
        else
        begin
            rd_mat = phase_reg ? MAT_B : MAT_A;
        end
    end

    assign cm_raddr = {rd_mat, row_idx, j_idx};
    assign vm_raddr = phase_reg ? {RGN_U, j_idx}
                                : {cur_rgn, (copy_row ? row_idx : j_idx)};

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        system_type_next  = system_type_reg;
        state_count_next  = state_count_reg;
        input_count_next  = input_count_reg;
        output_count_next = output_count_reg;
        present_next      = present_reg;
        state_valid_next  = state_valid_reg;
        bank_next         = bank_reg;
        op_out_next       = op_out_reg;
        add_in_next       = add_in_reg;
        phase_next        = phase_reg;
        run_status_next   = run_status_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        lim_next          = lim_reg;
        row_next          = row_reg;
        j_next            = j_reg;
        res_pending_next  = res_pending_reg || mac_res.done;
        term_next         = '0;

        cm_we    = 1'b0;
        cm_waddr = clr_reg;
        cm_wdata = '0;
        vm_we    = 1'b0;
        vm_waddr = clr_reg[VADDR_W-1:0];
        vm_wdata = '0;

        load_out  = 1'b0;
        ld_status = STS_OK;
        ld_index  = '0;
        ld_value  = '0;
        ld_last   = 1'b1;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYSTEM_TYPE:  system_type_next  = cfg_data[TYPE_W-1:0];
                CFG_STATE_COUNT:  state_count_next  = cfg_data[COUNT_W-1:0];
                CFG_INPUT_COUNT:  input_count_next  = cfg_data[COUNT_W-1:0];
                CFG_OUTPUT_COUNT: output_count_next = cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                cm_we    = 1'b1;
                vm_we    = 1'b1;
                clr_next = clr_reg + CADDR_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    row_next   = '0;
                    j_next     = '0;
                    phase_next = 1'b0;
                    n_next     = clamp_count(state_count_reg, MAX_STATES);
                    m_next     = clamp_count(input_count_reg, MAX_INPUTS);
                    case (kind)
                        KIND_LOAD_COEF:
                        begin
                            load_out = 1'b1;
                            if (coef_in_range)
                            begin
                                cm_we    = 1'b1;
                                cm_waddr = {matrix_sel, IDX_W'(row), IDX_W'(column)};
                                cm_wdata = value;
                                present_next[matrix_sel] = 1'b1;
                            end
                        end

                        KIND_LOAD_STATE:
                        begin
                            load_out = 1'b1;
                            if (row_lt_s)
                            begin
                                vm_we            = 1'b1;
                                vm_waddr         = {cur_rgn, IDX_W'(row)};
                                vm_wdata         = value;
                                state_valid_next = 1'b1;
                            end
                        end

                        KIND_LOAD_INPUT:
                        begin
                            load_out = 1'b1;
                            if (row_lt_i)
                            begin
                                vm_we    = 1'b1;
                                vm_waddr = {RGN_U, IDX_W'(row)};
                                vm_wdata = value;
                            end
                        end

                        KIND_UPDATE:
                        begin
                            op_out_next = 1'b0;
                            lim_next    = CW'(MAX_STATES);
                            if (!present_reg[MAT_A])
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_NO_A;
                            end
                            else if (!state_valid_reg)
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_NO_STATE;
                            end
                            else if (system_type_reg == SYS_UNSET)
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_TYPE_UNSET;
                            end
                            else if (system_type_reg == SYS_AUTONOMOUS)
                            begin
                                // input given to an autonomous system: ignored, warned
                                add_in_next     = 1'b0;
                                run_status_next = use_input ? STS_INPUT_IGNORED : STS_OK;
                                state_next      = S_ISSUE;
                            end
                            else if (!use_input)
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_INPUT_REQUIRED;
                            end
                            else if (!present_reg[MAT_B])
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_NO_B;
                            end
                            else
                            begin
                                add_in_next     = 1'b1;
                                run_status_next = STS_OK;
                                state_next      = S_ISSUE;
                            end
                        end

                        KIND_OUTPUT:
                        begin
                            op_out_next = 1'b1;
                            lim_next    = clamp_count(output_count_reg, OUT_LIMIT);
                            if (!present_reg[MAT_C])
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_NO_C;
                            end
                            else if (!state_valid_reg)
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_NO_STATE;
                            end
                            else if (system_type_reg == SYS_UNSET)
                            begin
                                load_out  = 1'b1;
                                ld_status = STS_TYPE_UNSET;
                            end
                            else if (system_type_reg == SYS_FEEDTHROUGH)
                            begin
                                if (!use_input)
                                begin
                                    load_out  = 1'b1;
                                    ld_status = STS_INPUT_REQUIRED;
                                end
                                else if (!present_reg[MAT_D])
                                begin
                                    load_out  = 1'b1;
                                    ld_status = STS_NO_D;
                                end
                                else
                                begin
                                    add_in_next     = 1'b1;
                                    run_status_next = STS_OK;
                                    state_next      = S_ISSUE;
                                end
                            end
                            else
                            begin
                                add_in_next     = 1'b0;
                                run_status_next = use_input ? STS_INPUT_IGNORED : STS_OK;
                                state_next      = S_ISSUE;
                            end
                        end

                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            S_ISSUE:
            begin
                term_next.valid = 1'b1;
                term_next.first = copy_row || (!phase_reg && (j_reg == '0));
                term_next.last  = term_last;
                term_next.copy  = copy_row;
                if (term_last)
                begin
                    j_next     = '0;
                    phase_next = 1'b0;
                    state_next = S_WAIT;
                end
                else if (!phase_reg && (j_inc == n_reg))
                begin
                    j_next     = '0;
                    phase_next = 1'b1;
                end
                else
                begin
                    j_next = j_inc;
                end
            end

            S_WAIT:
            begin
                if (res_ready)
                begin
                    if (!op_out_reg)
                    begin
                        vm_we            = 1'b1;
                        vm_waddr         = {oth_rgn, row_idx};
                        vm_wdata         = mac_res.value;
                        res_pending_next = 1'b0;
                        row_next         = row_inc;
                        if (row_inc == lim_reg)
                        begin
                            bank_next  = !bank_reg;
                            load_out   = 1'b1;
                            ld_status  = run_status_reg;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_ISSUE;
                        end
                    end
                    else if (!out_valid_reg || out_ready)
                    begin
                        load_out         = 1'b1;
                        ld_status        = run_status_reg;
                        ld_index         = POS_W'(row_reg);
                        ld_value         = mac_res.value;
                        ld_last          = (row_inc == lim_reg);
                        res_pending_next = 1'b0;
                        row_next         = row_inc;
                        state_next       = (row_inc == lim_reg) ? S_IDLE : S_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            system_type_reg  <= SYS_UNSET;
            state_count_reg  <= COUNT_RESET;
            input_count_reg  <= COUNT_RESET;
            output_count_reg <= COUNT_RESET;
            present_reg      <= '0;
            state_valid_reg  <= 1'b0;
            bank_reg         <= 1'b0;
            op_out_reg       <= 1'b0;
            add_in_reg       <= 1'b0;
            phase_reg        <= 1'b0;
            run_status_reg   <= STS_OK;
            n_reg            <= '0;
            m_reg            <= '0;
            lim_reg          <= '0;
            row_reg          <= '0;
            j_reg            <= '0;
            res_pending_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            term_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            system_type_reg  <= system_type_next;
            state_count_reg  <= state_count_next;
            input_count_reg  <= input_count_next;
            output_count_reg <= output_count_next;
            present_reg      <= present_next;
            state_valid_reg  <= state_valid_next;
            bank_reg         <= bank_next;
            op_out_reg       <= op_out_next;
            add_in_reg       <= add_in_next;
            phase_reg        <= phase_next;
            run_status_reg   <= run_status_next;
            n_reg            <= n_next;
            m_reg            <= m_next;
            lim_reg          <= lim_next;
            row_reg          <= row_next;
            j_reg            <= j_next;
            res_pending_reg  <= res_pending_next;
            out_valid_reg    <= out_valid_next;
            term_reg         <= term_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg    <= ld_status;
            index_reg     <= ld_index;
            out_value_reg <= ld_value;
            last_reg      <= ld_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            coef_mem[cm_waddr] <= cm_wdata;
        end
        coef_rd_reg <= coef_mem[cm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vec_mem[vm_waddr] <= vm_wdata;
        end
        vec_rd_reg <= vec_mem[vm_raddr];
    end

    ssm_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .term  (term_reg),
        .coef  (coef_rd_reg),
        .vec   (vec_rd_reg),
        .res   (mac_res)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

endmodule
